### rtl/mtep_pkg.sv
// shared types and constants of the midi track event parser
package mtep_pkg;

    // longest variable-length number, in bytes
    localparam logic [2:0] MAX_VARLEN_BYTES = 3'd4;

    // status and meta codes
    localparam logic [7:0] STATUS_META    = 8'hFF;
    localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
    localparam logic [7:0] STATUS_ESCAPE  = 8'hF7;
    localparam logic [7:0] META_END_TRACK = 8'h2F;
    localparam logic [7:0] META_TEMPO     = 8'h51;

    // event kinds
    localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
    localparam logic [3:0] KIND_PROGRAM    = 4'hC;
    localparam logic [3:0] KIND_CHAN_PRESS = 4'hD;
    localparam logic [3:0] KIND_END        = 4'hF;
    localparam logic [3:0] CHANNEL_END     = 4'hF;

    typedef enum logic [3:0] {
        PH_DELTA      = 4'd0,
        PH_STATUS     = 4'd1,
        PH_PARAM1     = 4'd2,
        PH_PARAM2     = 4'd3,
        PH_META_TYPE  = 4'd4,
        PH_META_LEN   = 4'd5,
        PH_META_DATA  = 4'd6,
        PH_SYSEX_LEN  = 4'd7,
        PH_SYSEX_DATA = 4'd8
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_track;
        logic       last_of_track;
    } track_byte_t;

    typedef struct packed {
        logic [31:0] delta_ticks;
        logic [3:0]  event_kind;
        logic [3:0]  event_channel;
        logic [7:0]  first_param;
        logic [7:0]  second_param;
        logic [23:0] tempo_now;
        logic        end_marker;
        logic        parse_error;
    } track_event_t;

endpackage

### rtl/midi_track_event_parser_core.sv
// midi track chunk parser: one byte in per cycle, decoded channel events out
// end markers and parse errors also leave through the result register
// throughput: one byte per cycle while m_ready does not stall, set by the
// single-pass phase logic between the byte register and the result register
// reset: aresetn low clears the parse state, tempo and both valid flags
module midi_track_event_parser_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  mtep_pkg::track_byte_t     s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output mtep_pkg::track_event_t    m_data
);
    import mtep_pkg::*;

    // byte register
    logic         in_valid_reg;
    track_byte_t  in_data_reg;
    // result register
    logic         m_valid_reg;
    track_event_t m_data_reg;

    // parse state
    phase_t      phase_reg, phase_next;
    logic [27:0] vl_value_reg, vl_value_next;
    logic [2:0]  vl_bytes_reg, vl_bytes_next;
    logic [31:0] pend_delta_reg, pend_delta_next;
    logic [3:0]  run_kind_reg, run_kind_next;
    logic [3:0]  run_chan_reg, run_chan_next;
    logic [3:0]  cur_kind_reg, cur_kind_next;
    logic [3:0]  cur_chan_reg, cur_chan_next;
    logic [7:0]  held_param_reg, held_param_next;
    logic [7:0]  meta_kind_reg, meta_kind_next;
    logic [27:0] skip_count_reg, skip_count_next;
    logic [23:0] tempo_reg, tempo_next;
    logic [1:0]  tempo_idx_reg, tempo_idx_next;
    logic        done_reg, done_next;

    // state as seen by this byte (start of track clears it)
    phase_t      cur_phase;
    logic [27:0] cur_vl_value;
    logic [2:0]  cur_vl_bytes;
    logic [31:0] cur_pend;
    logic [3:0]  cur_run_kind, cur_run_chan;
    logic [23:0] cur_tempo;
    logic        cur_done;

    logic [7:0]   b;
    logic         first, last;
    logic [27:0]  vl_shift;
    logic [2:0]   vl_count;
    logic         vl_long;
    logic [32:0]  delta_sum;
    logic         ev_fire;
    logic [7:0]   ev_p2;
    logic         emit, err;
    logic         advance;
    track_event_t res;

    assign b     = in_data_reg.data_byte;
    assign first = in_data_reg.first_of_track;
    assign last  = in_data_reg.last_of_track;

    // handshake
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // start of track restores the reset view of the state
    assign cur_phase    = first ? PH_DELTA : phase_reg;
    assign cur_vl_value = first ? '0 : vl_value_reg;
    assign cur_vl_bytes = first ? '0 : vl_bytes_reg;
    assign cur_pend     = first ? '0 : pend_delta_reg;
    assign cur_run_kind = first ? '0 : run_kind_reg;
    assign cur_run_chan = first ? '0 : run_chan_reg;
    assign cur_tempo    = first ? '0 : tempo_reg;
    assign cur_done     = first ? 1'b0 : done_reg;

    // variable-length number step
    assign vl_shift  = {cur_vl_value[20:0], b[6:0]};
    assign vl_count  = cur_vl_bytes + 3'd1;
    assign vl_long   = b[7] && (vl_count >= MAX_VARLEN_BYTES);
    assign delta_sum = {1'b0, cur_pend} + {5'd0, vl_shift};

    // next state and result
    always_comb begin
        phase_next      = cur_phase;
        vl_value_next   = cur_vl_value;
        vl_bytes_next   = cur_vl_bytes;
        pend_delta_next = cur_pend;
        run_kind_next   = cur_run_kind;
        run_chan_next   = cur_run_chan;
        cur_kind_next   = first ? '0 : cur_kind_reg;
        cur_chan_next   = first ? '0 : cur_chan_reg;
        held_param_next = first ? '0 : held_param_reg;
        meta_kind_next  = first ? '0 : meta_kind_reg;
        skip_count_next = first ? '0 : skip_count_reg;
        tempo_next      = cur_tempo;
        tempo_idx_next  = first ? '0 : tempo_idx_reg;
        done_next       = cur_done;
        ev_fire         = 1'b0;
        ev_p2           = '0;
        emit            = 1'b0;
        err             = 1'b0;
        res             = '0;

        if (!cur_done) begin
            case (cur_phase)
                PH_DELTA: begin
                    if (vl_long) begin
                        err = 1'b1;
                    end else if (b[7]) begin
                        vl_value_next = vl_shift;
                        vl_bytes_next = vl_count;
                    end else begin
                        pend_delta_next = delta_sum[32] ? '1 : delta_sum[31:0];
                        vl_value_next   = '0;
                        vl_bytes_next   = '0;
                        phase_next      = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (b == STATUS_META) begin
                        phase_next = PH_META_TYPE;
                    end else if (b inside {STATUS_SYSEX, STATUS_ESCAPE}) begin
                        phase_next = PH_SYSEX_LEN;
                    end else if (b[7]) begin
                        cur_kind_next = b[7:4];
                        cur_chan_next = b[3:0];
                        phase_next    = PH_PARAM1;
                    end else begin
                        // running status
                        cur_kind_next   = cur_run_kind;
                        cur_chan_next   = cur_run_chan;
                        held_param_next = b;
                        if (cur_run_kind inside {KIND_PROGRAM, KIND_CHAN_PRESS}) begin
                            ev_fire = 1'b1;
                        end else begin
                            phase_next = PH_PARAM2;
                        end
                    end
                end
                PH_PARAM1: begin
                    held_param_next = b;
                    if (cur_kind_next inside {KIND_PROGRAM, KIND_CHAN_PRESS}) begin
                        ev_fire = 1'b1;
                    end else begin
                        phase_next = PH_PARAM2;
                    end
                end
                PH_PARAM2: begin
                    ev_fire = 1'b1;
                    ev_p2   = b;
                end
                PH_META_TYPE: begin
                    meta_kind_next = b;
                    if (b == META_END_TRACK) begin
                        emit              = 1'b1;
                        res.delta_ticks   = cur_pend;
                        res.event_kind    = KIND_END;
                        res.event_channel = CHANNEL_END;
                        res.first_param   = META_END_TRACK;
                        res.end_marker    = 1'b1;
                        pend_delta_next   = '0;
                        done_next         = 1'b1;
                        phase_next        = PH_DELTA;
                    end else begin
                        phase_next = PH_META_LEN;
                    end
                end
                PH_META_LEN, PH_SYSEX_LEN: begin
                    if (vl_long) begin
                        err = 1'b1;
                    end else if (b[7]) begin
                        vl_value_next = vl_shift;
                        vl_bytes_next = vl_count;
                    end else begin
                        skip_count_next = vl_shift;
                        vl_value_next   = '0;
                        vl_bytes_next   = '0;
                        tempo_idx_next  = '0;
                        if (vl_shift == '0) begin
                            phase_next = PH_DELTA;
                        end else if (cur_phase == PH_META_LEN) begin
                            phase_next = PH_META_DATA;
                        end else begin
                            phase_next = PH_SYSEX_DATA;
                        end
                    end
                end
                PH_META_DATA, PH_SYSEX_DATA: begin
                    // tempo bytes shift in, at most three
                    if (cur_phase == PH_META_DATA && meta_kind_next == META_TEMPO &&
                        tempo_idx_next != 2'd3) begin
                        if (tempo_idx_next == 2'd0) begin
                            tempo_next = {16'd0, b};
                        end else begin
                            tempo_next = {cur_tempo[15:0], b};
                        end
                        tempo_idx_next = tempo_idx_next + 2'd1;
                    end
                    skip_count_next = skip_count_next - 28'd1;
                    if (skip_count_next == '0) begin
                        phase_next = PH_DELTA;
                    end
                end
                default: begin
                    phase_next    = PH_DELTA;
                    vl_value_next = '0;
                    vl_bytes_next = '0;
                end
            endcase

            // channel event complete
            if (ev_fire) begin
                emit              = 1'b1;
                run_kind_next     = cur_kind_next;
                run_chan_next     = cur_chan_next;
                res.delta_ticks   = pend_delta_next;
                res.event_kind    = (cur_kind_next == KIND_NOTE_ON && ev_p2 == '0) ?
                                    KIND_NOTE_OFF : cur_kind_next;
                res.event_channel = cur_chan_next;
                res.first_param   = held_param_next;
                res.second_param  = ev_p2;
                pend_delta_next   = '0;
                phase_next        = PH_DELTA;
            end

            // chunk ends inside an event
            if (!emit && last && (phase_next != PH_DELTA || vl_bytes_next != '0)) begin
                err = 1'b1;
            end

            if (err) begin
                emit            = 1'b1;
                res             = '0;
                res.parse_error = 1'b1;
                done_next       = 1'b1;
                phase_next      = PH_DELTA;
                vl_value_next   = '0;
                vl_bytes_next   = '0;
            end
        end
        res.tempo_now = tempo_next;
    end

    // byte register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_DELTA;
            vl_value_reg   <= '0;
            vl_bytes_reg   <= '0;
            pend_delta_reg <= '0;
            run_kind_reg   <= '0;
            run_chan_reg   <= '0;
            cur_kind_reg   <= '0;
            cur_chan_reg   <= '0;
            held_param_reg <= '0;
            meta_kind_reg  <= '0;
            skip_count_reg <= '0;
            tempo_reg      <= '0;
            tempo_idx_reg  <= '0;
            done_reg       <= 1'b0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            vl_value_reg   <= vl_value_next;
            vl_bytes_reg   <= vl_bytes_next;
            pend_delta_reg <= pend_delta_next;
            run_kind_reg   <= run_kind_next;
            run_chan_reg   <= run_chan_next;
            cur_kind_reg   <= cur_kind_next;
            cur_chan_reg   <= cur_chan_next;
            held_param_reg <= held_param_next;
            meta_kind_reg  <= meta_kind_next;
            skip_count_reg <= skip_count_next;
            tempo_reg      <= tempo_next;
            tempo_idx_reg  <= tempo_idx_next;
            done_reg       <= done_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && emit) begin
            m_data_reg <= res;
        end
    end

`ifndef SYNTH
    // end marker and error never share a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.end_marker && m_data.parse_error))
        else $error("end marker and parse error in one result");

    // end marker carries the end-of-track code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.end_marker |->
            m_data.event_kind == KIND_END && m_data.first_param == META_END_TRACK)
        else $error("malformed end marker");

    // error result has cleared event fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.parse_error |->
            m_data.delta_ticks == '0 && m_data.event_kind == '0 &&
            m_data.first_param == '0 && m_data.second_param == '0)
        else $error("error result with event fields set");

    // note-on with zero velocity is never reported
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind == KIND_NOTE_ON |-> m_data.second_param != '0)
        else $error("note-on with zero velocity");

    // a finished track stays silent until the next track start
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && done_reg && !in_data_reg.first_of_track |=>
            $stable(pend_delta_reg) && $stable(tempo_reg))
        else $error("state changed after end of track");
`endif

endmodule
